@@ hdl/swk_pkg.sv @@
`timescale 1ns / 1ps
package swk_pkg;

    localparam int ATAN_LEN      = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int ROT_W   = 34;
    localparam int VEC_W   = 48;
    localparam int MAG_W   = 25;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int REM_W   = MAG_W + 3;
    localparam int MX_W    = 24;
    localparam int T_W     = 33;
    localparam int PROD_W  = MAG_W + 16;

    localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [15:0] BODY_RADIUS_RST      = 16'd4096;
    localparam logic [15:0] INV_WHEEL_RADIUS_RST = 16'd2560;

    localparam logic [1:0] REG_BODY_RADIUS      = 2'd0;
    localparam logic [1:0] REG_INV_WHEEL_RADIUS = 2'd1;

    localparam logic [31:0] MODULE_OFF [0:2] = '{32'd357913941, 32'd1789569707,
                                                 32'd3221225472};

    function automatic logic [31:0] atan_val(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/swk_cmd_if.sv @@
`timescale 1ns / 1ps
interface swk_cmd_if;
    logic        valid;
    logic        ready;
    logic [15:0] vel_x;
    logic [15:0] vel_y;
    logic [15:0] yaw_rate;
    logic [15:0] heading;
    modport source (output valid, vel_x, vel_y, yaw_rate, heading, input ready);
    modport sink (input valid, vel_x, vel_y, yaw_rate, heading, output ready);
endinterface

@@ hdl/swk_res_if.sv @@
`timescale 1ns / 1ps
interface swk_res_if;
    logic        valid;
    logic        ready;
    logic [23:0] wheel_speed_a;
    logic [23:0] wheel_speed_b;
    logic [23:0] wheel_speed_c;
    logic [15:0] steer_angle_a;
    logic [15:0] steer_angle_b;
    logic [15:0] steer_angle_c;
    modport source (output valid, wheel_speed_a, wheel_speed_b, wheel_speed_c,
                    steer_angle_a, steer_angle_b, steer_angle_c, input ready);
    modport sink (input valid, wheel_speed_a, wheel_speed_b, wheel_speed_c,
                  steer_angle_a, steer_angle_b, steer_angle_c, output ready);
endinterface

@@ hdl/swk_cfg_if.sv @@
`timescale 1ns / 1ps
interface swk_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/swk_rot_cell.sv @@
`timescale 1ns / 1ps
module swk_rot_cell
    import swk_pkg::*;
#(
    parameter int IDX = 0,
    parameter int PW  = 1
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [ROT_W-1:0] x_in,
    input  logic signed [ROT_W-1:0] y_in,
    input  logic signed [ROT_W-1:0] z_in,
    input  logic [PW-1:0]           p_in,
    output logic signed [ROT_W-1:0] x_out,
    output logic signed [ROT_W-1:0] y_out,
    output logic signed [ROT_W-1:0] z_out,
    output logic [PW-1:0]           p_out
);

    localparam logic signed [ROT_W-1:0] ATAN = $signed({2'b00, atan_val(IDX)});

    logic signed [ROT_W-1:0] x_reg, y_reg, z_reg;
    logic signed [ROT_W-1:0] x_next, y_next, z_next;
    logic [PW-1:0]           p_reg;
    logic signed [ROT_W-1:0] dx, dy;

    always_comb
    begin
        dx = y_in >>> IDX;
        dy = x_in >>> IDX;
        if (z_in >= 0)
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            p_reg <= p_in;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign p_out = p_reg;

endmodule

@@ hdl/swk_sqrt_cell.sv @@
`timescale 1ns / 1ps
module swk_sqrt_cell
    import swk_pkg::*;
#(
    parameter int IDX = 0,
    parameter int PW  = 1
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [REM_W-1:0] rem_in,
    input  logic [MAG_W-1:0] q_in,
    input  logic [SQ_W-1:0]  v_in,
    input  logic [PW-1:0]    p_in,
    output logic [REM_W-1:0] rem_out,
    output logic [MAG_W-1:0] q_out,
    output logic [SQ_W-1:0]  v_out,
    output logic [PW-1:0]    p_out
);

    logic [REM_W-1:0] rem_reg, rem_next, rem_sh, trial;
    logic [MAG_W-1:0] q_reg, q_next;
    logic [SQ_W-1:0]  v_reg;
    logic [PW-1:0]    p_reg;
    logic             ge;

    always_comb
    begin
        rem_sh = {rem_in[REM_W-3:0], v_in[SQ_W-1-2*IDX -: 2]};
        trial  = REM_W'({q_in, 2'b01});
        ge     = (rem_sh >= trial);
        rem_next = ge ? (rem_sh - trial) : rem_sh;
        q_next   = {q_in[MAG_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
            v_reg   <= v_in;
            p_reg   <= p_in;
        end
    end

    assign rem_out = rem_reg;
    assign q_out   = q_reg;
    assign v_out   = v_reg;
    assign p_out   = p_reg;

endmodule

@@ hdl/swk_vec_cell.sv @@
`timescale 1ns / 1ps
module swk_vec_cell
    import swk_pkg::*;
#(
    parameter int IDX = 0,
    parameter int PW  = 1
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [VEC_W-1:0] x_in,
    input  logic signed [VEC_W-1:0] y_in,
    input  logic [31:0]             z_in,
    input  logic [PW-1:0]           p_in,
    output logic signed [VEC_W-1:0] x_out,
    output logic signed [VEC_W-1:0] y_out,
    output logic [31:0]             z_out,
    output logic [PW-1:0]           p_out
);

    localparam logic [31:0] ATAN = atan_val(IDX);

    logic signed [VEC_W-1:0] x_reg, y_reg, x_next, y_next, dx, dy;
    logic [31:0]             z_reg, z_next;
    logic [PW-1:0]           p_reg;

    always_comb
    begin
        dx = y_in >>> IDX;
        dy = x_in >>> IDX;
        if (y_in > 0)
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            p_reg <= p_in;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign p_out = p_reg;

endmodule

@@ hdl/swerve_wheel_kinematics.sv @@
`timescale 1ns / 1ps
// Inverse kinematics for a three-wheel swerve base (modules at 30, 150, 270 deg).
// cmd: one word per body command (vel_x, vel_y, yaw_rate, heading), valid/ready.
// res: one word per command with the three wheel speeds and steer angles.
// cfg: register writes (0 body_radius, 1 inv_wheel_radius), always ready;
//      write only while no command is in flight.
// Each lane runs a rotation CORDIC, a digit-by-digit square root and a
// vectoring CORDIC as chains of cells that advance together whenever the output slot is free or being taken.
// Throughput: one word per cycle while res does not stall.
// When res stalls the whole chain holds and cmd.ready drops in the same
// cycle; a result word waits in the output register until taken.
// Reset clears all valid flags and loads the register defaults
// (body_radius 1.0 m, inv_wheel_radius 10 /m); no clearing pass.
module swerve_wheel_kinematics
    import swk_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    swk_cmd_if.sink cmd,
    swk_res_if.source res,
    swk_cfg_if.sink cfg
);

    localparam int NS    = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    localparam int DEPTH = 2 * NS + 5 + MAG_W;
    localparam int RPW   = 1 + 16 + 16 + T_W;
    localparam int SPW   = 2 * MX_W;
    localparam int VPW   = 1 + PROD_W;
    localparam logic signed [ROT_W-1:0] QTURN = 34'sd1073741824;
    localparam logic signed [ROT_W-1:0] HTURN = 34'sd2147483648;

    logic [15:0]  body_radius_reg, inv_wheel_radius_reg;
    logic         adv;
    logic [DEPTH-1:0] vld_reg;
    logic         out_vld_reg;
    logic [15:0]  vx0_reg, vy0_reg;
    logic signed [T_W-1:0] t0_reg;
    logic [23:0]  spd_out [0:2];
    logic [15:0]  ang_out [0:2];
    logic [23:0]  spd_reg [0:2];
    logic [15:0]  ang_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_radius_reg      <= BODY_RADIUS_RST;
            inv_wheel_radius_reg <= INV_WHEEL_RADIUS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_BODY_RADIUS:      body_radius_reg      <= cfg.data;
                REG_INV_WHEEL_RADIUS: inv_wheel_radius_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // advance whenever the output slot is free or being taken
    assign adv       = !out_vld_reg || res.ready;
    assign cmd.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[DEPTH-2:0], cmd.valid};
            out_vld_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vx0_reg <= cmd.vel_x;
            vy0_reg <= cmd.vel_y;
            t0_reg  <= $signed(cmd.yaw_rate) * $signed({1'b0, body_radius_reg});
            for (int k = 0; k < 3; k++)
            begin
                spd_reg[k] <= spd_out[k];
                ang_reg[k] <= ang_out[k];
            end
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        logic [31:0]             ph;
        logic signed [ROT_W-1:0] zs;
        logic signed [ROT_W-1:0] z0_reg;
        logic                    flip0_reg;
        logic signed [ROT_W-1:0] rx [0:NS];
        logic signed [ROT_W-1:0] ry [0:NS];
        logic signed [ROT_W-1:0] rz [0:NS];
        logic [RPW-1:0]          rp [0:NS];
        logic                    flip1;
        logic [15:0]             vx1, vy1;
        logic signed [T_W-1:0]   t1;
        logic signed [ROT_W-1:0] cf, sf;
        logic signed [66:0]      ps_reg, pc_reg, rs_sum, rc_sum;
        logic [15:0]             vx2_reg, vy2_reg;
        logic signed [MX_W-1:0]  mx3_reg, my3_reg, mx4_reg, my4_reg, mx5_reg, my5_reg;
        logic signed [47:0]      sqx_reg, sqy_reg;
        logic [47:0]             sqsum;
        logic [SQ_W-1:0]         v_reg;
        logic [REM_W-1:0]        sr [0:MAG_W];
        logic [MAG_W-1:0]        sq [0:MAG_W];
        logic [SQ_W-1:0]         sv [0:MAG_W];
        logic [SPW-1:0]          sp [0:MAG_W];
        logic signed [MX_W-1:0]  mxs, mys;
        logic signed [VEC_W-1:0] mxw, myw;
        logic signed [VEC_W-1:0] vxa [0:NS];
        logic signed [VEC_W-1:0] vya [0:NS];
        logic [31:0]             vza [0:NS];
        logic [VPW-1:0]          vpa [0:NS];
        logic [PROD_W:0]         pd;
        logic [31:0]             zr;

        assign ph = {cmd.heading, 16'h0000} + MODULE_OFF[k];
        assign zs = $signed({{2{ph[31]}}, ph});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (zs > QTURN)
                begin
                    z0_reg    <= zs - HTURN;
                    flip0_reg <= 1'b1;
                end
                else if (zs < -QTURN)
                begin
                    z0_reg    <= zs + HTURN;
                    flip0_reg <= 1'b1;
                end
                else
                begin
                    z0_reg    <= zs;
                    flip0_reg <= 1'b0;
                end
            end
        end

        assign rx[0] = CORDIC_GAIN;
        assign ry[0] = '0;
        assign rz[0] = z0_reg;
        assign rp[0] = {flip0_reg, vx0_reg, vy0_reg, t0_reg};

        for (genvar i = 0; i < NS; i++)
        begin : g_rot
            swk_rot_cell #(.IDX(i), .PW(RPW)) u_cell (
                .clk   (clk),
                .en    (adv),
                .x_in  (rx[i]),
                .y_in  (ry[i]),
                .z_in  (rz[i]),
                .p_in  (rp[i]),
                .x_out (rx[i+1]),
                .y_out (ry[i+1]),
                .z_out (rz[i+1]),
                .p_out (rp[i+1])
            );
        end

        assign {flip1, vx1, vy1, t1} = rp[NS];
        assign cf = flip1 ? -rx[NS] : rx[NS];
        assign sf = flip1 ? -ry[NS] : ry[NS];

        assign rs_sum = ps_reg + 67'sd2199023255552;
        assign rc_sum = pc_reg + 67'sd2199023255552;
        assign sqsum  = sqx_reg + sqy_reg;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ps_reg  <= t1 * sf;
                pc_reg  <= t1 * cf;
                vx2_reg <= vx1;
                vy2_reg <= vy1;
                mx3_reg <= MX_W'($signed(vx2_reg)) - $signed(rs_sum[65:42]);
                my3_reg <= MX_W'($signed(vy2_reg)) + $signed(rc_sum[65:42]);
                sqx_reg <= mx3_reg * mx3_reg;
                sqy_reg <= my3_reg * my3_reg;
                mx4_reg <= mx3_reg;
                my4_reg <= my3_reg;
                v_reg   <= {sqsum[SQ_W-9:0], 8'h00};
                mx5_reg <= mx4_reg;
                my5_reg <= my4_reg;
            end
        end

        assign sr[0] = '0;
        assign sq[0] = '0;
        assign sv[0] = v_reg;
        assign sp[0] = {mx5_reg, my5_reg};

        for (genvar i = 0; i < MAG_W; i++)
        begin : g_sqrt
            swk_sqrt_cell #(.IDX(i), .PW(SPW)) u_cell (
                .clk     (clk),
                .en      (adv),
                .rem_in  (sr[i]),
                .q_in    (sq[i]),
                .v_in    (sv[i]),
                .p_in    (sp[i]),
                .rem_out (sr[i+1]),
                .q_out   (sq[i+1]),
                .v_out   (sv[i+1]),
                .p_out   (sp[i+1])
            );
        end

        assign {mxs, mys} = sp[MAG_W];
        assign mxw = VEC_W'(mxs) <<< 20;
        assign myw = VEC_W'(mys) <<< 20;
        assign vxa[0] = mxs[MX_W-1] ? -mxw : mxw;
        assign vya[0] = mxs[MX_W-1] ? -myw : myw;
        assign vza[0] = mxs[MX_W-1] ? 32'h80000000 : 32'h0;
        assign vpa[0] = {(mxs == '0) && (mys == '0),
                         sq[MAG_W] * PROD_W'(inv_wheel_radius_reg)};

        for (genvar i = 0; i < NS; i++)
        begin : g_vec
            swk_vec_cell #(.IDX(i), .PW(VPW)) u_cell (
                .clk   (clk),
                .en    (adv),
                .x_in  (vxa[i]),
                .y_in  (vya[i]),
                .z_in  (vza[i]),
                .p_in  (vpa[i]),
                .x_out (vxa[i+1]),
                .y_out (vya[i+1]),
                .z_out (vza[i+1]),
                .p_out (vpa[i+1])
            );
        end

        assign pd = {1'b0, vpa[NS][PROD_W-1:0]} + (PROD_W+1)'(32768);
        assign zr = vza[NS] + 32'h00008000;
        assign spd_out[k] = (|pd[PROD_W:40]) ? 24'hFFFFFF : pd[39:16];
        assign ang_out[k] = vpa[NS][PROD_W] ? 16'h0000 : zr[31:16];
    end

    assign res.valid         = out_vld_reg;
    assign res.wheel_speed_a = spd_reg[0];
    assign res.wheel_speed_b = spd_reg[1];
    assign res.wheel_speed_c = spd_reg[2];
    assign res.steer_angle_a = ang_reg[0];
    assign res.steer_angle_b = ang_reg[1];
    assign res.steer_angle_c = ang_reg[2];

endmodule

@@ bench/swerve_wheel_kinematics_checker.sv @@
`timescale 1ns / 1ps
module swerve_wheel_kinematics_checker
    import swk_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    swk_cmd_if.sink   cmd,
    swk_res_if.sink   res,
    swk_cfg_if.sink   cfg,
    output int        fail_count,
    output int        pending
);

    typedef struct packed {
        logic [23:0] spd_a;
        logic [23:0] spd_b;
        logic [23:0] spd_c;
        logic [15:0] ang_a;
        logic [15:0] ang_b;
        logic [15:0] ang_c;
    } wheel_set_t;

    wheel_set_t wheel_q[$];
    logic [15:0] radius_reg;
    logic [15:0] inv_wr_reg;

    assign pending = wheel_q.size();

    function automatic int n_stages();
        return (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    endfunction

    function automatic longint atan_entry(input int i);
        case (i)
            0:  return 64'h20000000;
            1:  return 64'h12E4051E;
            2:  return 64'h09FB385B;
            3:  return 64'h051111D4;
            4:  return 64'h028B0D43;
            5:  return 64'h0145D7E1;
            6:  return 64'h00A2F61E;
            7:  return 64'h00517C55;
            8:  return 64'h0028BE53;
            9:  return 64'h00145F2F;
            10: return 64'h000A2F98;
            11: return 64'h000517CC;
            12: return 64'h00028BE6;
            13: return 64'h000145F3;
            14: return 64'h0000A2FA;
            15: return 64'h0000517D;
            16: return 64'h000028BE;
            17: return 64'h0000145F;
            18: return 64'h00000A30;
            19: return 64'h00000518;
            20: return 64'h0000028C;
            21: return 64'h00000146;
            22: return 64'h000000A3;
            default: return 64'h00000051;
        endcase
    endfunction

    function automatic void phase_sincos(input logic [31:0] ph, output longint c,
                                         output longint s);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'(ph);
        x = 652032874;
        y = 0;
        flip = 0;
        if (z >= 64'sd2147483648) z -= 64'sd4294967296;
        if (z > 64'sd1073741824) begin z -= 64'sd2147483648; flip = 1; end
        else if (z < -64'sd1073741824) begin z += 64'sd2147483648; flip = 1; end
        for (int i = 0; i < n_stages(); i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin x -= dx; y += dy; z -= atan_entry(i); end
            else begin x += dx; y -= dy; z += atan_entry(i); end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b) begin v -= r + b; r = (r >> 1) + b; end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] steer_of(input longint mx, input longint my);
        longint x, y, dx, dy;
        logic [31:0] z;
        if (mx == 0 && my == 0) return 16'd0;
        x = mx * 1048576;
        y = my * 1048576;
        z = 0;
        if (x < 0) begin x = -x; y = -y; z = 32'h80000000; end
        for (int i = 0; i < n_stages(); i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin x += dx; y -= dy; z += atan_entry(i); end
            else begin x -= dx; y += dy; z -= atan_entry(i); end
        end
        z = z + 32'h8000;
        return z[31:16];
    endfunction

    function automatic wheel_set_t wheels_for(input logic signed [15:0] vx,
                                              input logic signed [15:0] vy,
                                              input logic signed [15:0] w,
                                              input logic [15:0] hd);
        wheel_set_t r;
        longint t, c, s, mx, my;
        longint unsigned sq, mag, spd;
        logic [23:0] sp [3];
        logic [15:0] an [3];
        t = longint'(w) * longint'({1'b0, radius_reg});
        for (int k = 0; k < 3; k++)
        begin
            phase_sincos({hd, 16'd0} + MODULE_OFF[k], c, s);
            mx = longint'(vx) - ((t * s + 64'sd2199023255552) >>> 42);
            my = longint'(vy) + ((t * c + 64'sd2199023255552) >>> 42);
            sq = longint'(mx * mx) + longint'(my * my);
            mag = int_sqrt(sq << 8);
            spd = (mag * inv_wr_reg + 32768) >> 16;
            if (spd > 64'hFFFFFF) spd = 64'hFFFFFF;
            sp[k] = spd[23:0];
            an[k] = steer_of(mx, my);
        end
        r = '{sp[0], sp[1], sp[2], an[0], an[1], an[2]};
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wheel_set_t got, want;
        if (!rst_n)
        begin
            radius_reg <= BODY_RADIUS_RST;
            inv_wr_reg <= INV_WHEEL_RADIUS_RST;
            fail_count <= 0;
            wheel_q.delete();
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                wheel_q.push_back(wheels_for(cmd.vel_x, cmd.vel_y, cmd.yaw_rate,
                                             cmd.heading));
            if (res.valid && res.ready)
            begin
                got = '{res.wheel_speed_a, res.wheel_speed_b, res.wheel_speed_c,
                        res.steer_angle_a, res.steer_angle_b, res.steer_angle_c};
                if (wheel_q.size() == 0)
                begin
                    if (fail_count < 10) $display("unexpected result word %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = wheel_q.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %h actual %h", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_BODY_RADIUS) radius_reg <= cfg.data;
                else if (cfg.index == REG_INV_WHEEL_RADIUS) inv_wr_reg <= cfg.data;
            end
        end
    end

endmodule

@@ bench/swerve_wheel_kinematics_tb.sv @@
`timescale 1ns / 1ps
module swerve_wheel_kinematics_tb;
    import swk_pkg::*;

    localparam int WATCHDOG = 20000;

    logic clk = 0;
    logic rst_n = 0;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    bit   timed_out = 0;

    swk_cmd_if cmd ();
    swk_res_if res ();
    swk_cfg_if cfg ();

    swerve_wheel_kinematics u_top (.clk(clk), .rst_n(rst_n), .cmd(cmd), .res(res),
                                   .cfg(cfg));
    swerve_wheel_kinematics_checker u_chk (.clk(clk), .rst_n(rst_n), .cmd(cmd),
                                           .res(res), .cfg(cfg),
                                           .fail_count(fail_count), .pending(pending));

    always #10 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // consumer side: random stalls, with calm stretches
    initial
    begin
        int g;
        res.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            g = gap_len();
            if ($urandom_range(0, 3) == 0) g = 0;
            if (g == 0)
                res.ready <= 1;
            else
            begin
                res.ready <= 0;
                repeat (g) @(negedge clk);
                res.ready <= 1;
            end
        end
    end

    task automatic send_word(input logic [15:0] vx, input logic [15:0] vy,
                             input logic [15:0] w, input logic [15:0] hd);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            cmd.valid <= 0;
            repeat (g) @(negedge clk);
        end
        cmd.valid <= 1;
        cmd.vel_x <= vx;
        cmd.vel_y <= vy;
        cmd.yaw_rate <= w;
        cmd.heading <= hd;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        @(negedge clk);
        cfg.valid <= 0;
        @(negedge clk);
    endtask

    // drop valid and hold until every result has come back
    task automatic wait_empty();
        cmd.valid <= 0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic drain();
        wait_empty();
        repeat (2 * CORDIC_STAGES_DEF + 40) @(negedge clk);
    endtask

    task automatic random_word();
        logic [15:0] v [4];
        for (int i = 0; i < 4; i++)
        begin
            case ($urandom_range(0, 5))
                0: v[i] = 16'h8000;
                1: v[i] = 16'h7FFF;
                2: v[i] = 16'($urandom_range(0, 15)) - 16'd8;
                default: v[i] = 16'($urandom);
            endcase
        end
        if ($urandom_range(0, 9) == 0) v[2] = 0;
        send_word(v[0], v[1], v[2], v[3]);
    endtask

    initial
    begin
        logic [15:0] radii [5];
        logic [15:0] invs [5];
        radii = '{16'd4096, 16'd0, 16'hFFFF, 16'd1024, 16'd0};
        invs  = '{16'd2560, 16'hFFFF, 16'd0, 16'd256, 16'd1};
        cmd.valid = 0; cmd.vel_x = 0; cmd.vel_y = 0; cmd.yaw_rate = 0; cmd.heading = 0;
        cfg.valid = 0; cfg.index = REG_BODY_RADIUS; cfg.data = 0;
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        send_word(16'd0, 16'd0, 16'd0, 16'd0);
        send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_word(16'h8000, 16'd0, 16'd0, 16'd0);
        send_word(16'h8000, 16'hFFFF, 16'd0, 16'd0);
        send_word(16'h8000, 16'd1, 16'd0, 16'd0);
        send_word(16'd0, 16'h7FFF, 16'd0, 16'h4000);
        send_word(16'd0, 16'h8000, 16'd0, 16'hC000);
        send_word(16'd0, 16'd0, 16'd4096, 16'd0);
        send_word(16'd0, 16'd0, 16'hF000, 16'h2AAB);
        send_word(16'h1000, 16'd0, 16'h1000, 16'h5555);
        send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001);
        drain();

        for (int p = 0; p < 5; p++)
        begin
            write_reg(REG_BODY_RADIUS, radii[p]);
            write_reg(REG_INV_WHEEL_RADIUS, invs[p]);
            if (p == 4) write_reg(2'd3, 16'h1234);
            for (int n = 0; n < 360; n++)
            begin
                random_word();
                if (n == 180)
                    wait_empty();
            end
            drain();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/swk_pkg.sv
hdl/swk_cmd_if.sv
hdl/swk_res_if.sv
hdl/swk_cfg_if.sv
hdl/swk_rot_cell.sv
hdl/swk_sqrt_cell.sv
hdl/swk_vec_cell.sv
hdl/swerve_wheel_kinematics.sv
bench/swerve_wheel_kinematics_checker.sv
bench/swerve_wheel_kinematics_tb.sv
